@@ rtl/core/fmv_pkg.sv @@
// shared types, codes and microprogram for the fm voice oscillator
package fmv_pkg;

  localparam int DEF_SAMPLE_RATE     = 44100;
  localparam int DEF_SINE_TABLE_SIZE = 1024;

  // configuration registers
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MOD_RATIO = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MOD_INDEX = 1'd1;
  localparam logic [15:0] MOD_RATIO_RST = 16'd4915;
  localparam logic [15:0] MOD_INDEX_RST = 16'd3677;

  // command kinds
  localparam logic [1:0] KIND_TICK   = 2'd0;
  localparam logic [1:0] KIND_NOTE   = 2'd1;
  localparam logic [1:0] KIND_STOP   = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] note;
    logic [6:0] velocity;
  } cmd_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               voice_active;
  } res_t;

  // sequencer codes
  localparam logic [1:0] SQ_NEXT   = 2'd0;
  localparam logic [1:0] SQ_BRANCH = 2'd1;
  localparam logic [1:0] SQ_END    = 2'd2;

  localparam logic [2:0] CD_NONE     = 3'd0;
  localparam logic [2:0] CD_NOT_TICK = 3'd1;
  localparam logic [2:0] CD_SILENT   = 3'd2;
  localparam logic [2:0] CD_STOP     = 3'd3;
  localparam logic [2:0] CD_UNUSED   = 3'd4;

  // multiplier operand pairs
  localparam logic [2:0] MA_NONE        = 3'd0;
  localparam logic [2:0] MA_MPHASE_N    = 3'd1;
  localparam logic [2:0] MA_INDEX_ROM   = 3'd2;
  localparam logic [2:0] MA_P_CPR       = 3'd3;
  localparam logic [2:0] MA_ARG_N       = 3'd4;
  localparam logic [2:0] MA_ROM_AMP     = 3'd5;
  localparam logic [2:0] MA_P_GAIN      = 3'd6;
  localparam logic [2:0] MA_CSTEP_RATIO = 3'd7;

  // datapath actions
  localparam logic [3:0] ACT_NONE      = 4'd0;
  localparam logic [3:0] ACT_ADDR      = 4'd1;
  localparam logic [3:0] ACT_ROM       = 4'd2;
  localparam logic [3:0] ACT_ARG       = 4'd3;
  localparam logic [3:0] ACT_EMIT      = 4'd4;
  localparam logic [3:0] ACT_EMIT_ZERO = 4'd5;
  localparam logic [3:0] ACT_LOAD      = 4'd6;
  localparam logic [3:0] ACT_MSTEP     = 4'd7;
  localparam logic [3:0] ACT_STOP      = 4'd8;

  localparam int UC_DEPTH = 22;
  localparam int PC_W     = $clog2(UC_DEPTH);

  // program entry points
  localparam logic [PC_W-1:0] ST_DISPATCH = 5'd0;
  localparam logic [PC_W-1:0] ST_SILENT   = 5'd14;
  localparam logic [PC_W-1:0] ST_CMD      = 5'd15;
  localparam logic [PC_W-1:0] ST_STOP     = 5'd20;
  localparam logic [PC_W-1:0] ST_NOP      = 5'd21;

  typedef struct packed {
    logic [1:0]      seq;
    logic [2:0]      cond;
    logic [PC_W-1:0] target;
    logic [2:0]      mul;
    logic [3:0]      act;
  } ctrl_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       sounding;
    logic       out_full;
  } stat_t;

  function automatic ctrl_t cw(input logic [1:0] seq, input logic [2:0] cond,
                               input logic [PC_W-1:0] target, input logic [2:0] mul,
                               input logic [3:0] act);
    ctrl_t w;
    w.seq    = seq;
    w.cond   = cond;
    w.target = target;
    w.mul    = mul;
    w.act    = act;
    return w;
  endfunction

  localparam ctrl_t UCODE [UC_DEPTH] = '{
    cw(SQ_BRANCH, CD_NOT_TICK, ST_CMD,      MA_NONE,        ACT_NONE),
    cw(SQ_BRANCH, CD_SILENT,   ST_SILENT,   MA_NONE,        ACT_NONE),
    // modulator sine
    cw(SQ_NEXT,   CD_NONE,     ST_DISPATCH, MA_MPHASE_N,    ACT_NONE),
    cw(SQ_NEXT,   CD_NONE,     ST_DISPATCH, MA_NONE,        ACT_ADDR),
    cw(SQ_NEXT,   CD_NONE,     ST_DISPATCH, MA_NONE,        ACT_ROM),
    // phase offset
    cw(SQ_NEXT,   CD_NONE,     ST_DISPATCH, MA_INDEX_ROM,   ACT_NONE),
    cw(SQ_NEXT,   CD_NONE,     ST_DISPATCH, MA_P_CPR,       ACT_NONE),
    cw(SQ_NEXT,   CD_NONE,     ST_DISPATCH, MA_NONE,        ACT_ARG),
    // carrier sine
    cw(SQ_NEXT,   CD_NONE,     ST_DISPATCH, MA_ARG_N,       ACT_NONE),
    cw(SQ_NEXT,   CD_NONE,     ST_DISPATCH, MA_NONE,        ACT_ADDR),
    cw(SQ_NEXT,   CD_NONE,     ST_DISPATCH, MA_NONE,        ACT_ROM),
    // output gain
    cw(SQ_NEXT,   CD_NONE,     ST_DISPATCH, MA_ROM_AMP,     ACT_NONE),
    cw(SQ_NEXT,   CD_NONE,     ST_DISPATCH, MA_P_GAIN,      ACT_NONE),
    cw(SQ_END,    CD_NONE,     ST_DISPATCH, MA_NONE,        ACT_EMIT),
    cw(SQ_END,    CD_NONE,     ST_DISPATCH, MA_NONE,        ACT_EMIT_ZERO),
    // note on, stop, unused
    cw(SQ_BRANCH, CD_STOP,     ST_STOP,     MA_NONE,        ACT_NONE),
    cw(SQ_BRANCH, CD_UNUSED,   ST_NOP,      MA_NONE,        ACT_NONE),
    cw(SQ_NEXT,   CD_NONE,     ST_DISPATCH, MA_NONE,        ACT_LOAD),
    cw(SQ_NEXT,   CD_NONE,     ST_DISPATCH, MA_CSTEP_RATIO, ACT_NONE),
    cw(SQ_END,    CD_NONE,     ST_DISPATCH, MA_NONE,        ACT_MSTEP),
    cw(SQ_END,    CD_NONE,     ST_DISPATCH, MA_NONE,        ACT_STOP),
    cw(SQ_END,    CD_NONE,     ST_DISPATCH, MA_NONE,        ACT_NONE)
  };

endpackage

@@ rtl/core/fm_voice_oscillator_core.sv @@
// top level of the two-operator fm voice oscillator
//
//  channel  signals                             beat moves
//  cmd      cmd_valid / cmd_stall / cmd         tick, note on or stop command
//  res      res_valid / res_stall / res         one sample per tick
//  cfg      cfg_valid / cfg_ready / cfg_index   mod_ratio or mod_index write
//
// a tick on a sounding voice runs 14 program steps, one per cycle unless a stalled result
// holds the emit step; a silent tick takes 3 steps, note on 6, stop 3, unused kind 4.
// the next command is taken only once the program has ended. the step count is set by the
// single shared 32x32 multiplier, used six times per sample, and the two registered sine rom reads.
// rst is synchronous; it restores register defaults and silences the voice.
// a stalled result holds the program at its emit step; until then the next
// command waits, while the result register itself parts the two sides.
module fm_voice_oscillator_core #(
  parameter int SAMPLE_RATE     = fmv_pkg::DEF_SAMPLE_RATE,
  parameter int SINE_TABLE_SIZE = fmv_pkg::DEF_SINE_TABLE_SIZE
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  output logic                          cmd_stall,
  input  fmv_pkg::cmd_t                 cmd,
  output logic                          res_valid,
  input  logic                          res_stall,
  output fmv_pkg::res_t                 res,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [fmv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                   cfg_data
);

  logic           busy;
  logic           cmd_take;
  fmv_pkg::ctrl_t ctrl;
  fmv_pkg::stat_t stat;

  assign cmd_stall = busy;
  assign cmd_take  = cmd_valid && !busy;
  assign cfg_ready = 1'b1;

  fmv_useq u_useq (
    .clk  (clk),
    .rst  (rst),
    .start(cmd_take),
    .stat (stat),
    .busy (busy),
    .ctrl (ctrl)
  );

  fmv_dpath #(
    .SAMPLE_RATE    (SAMPLE_RATE),
    .SINE_TABLE_SIZE(SINE_TABLE_SIZE)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cmd_take (cmd_take),
    .cmd      (cmd),
    .ctrl     (ctrl),
    .stat     (stat),
    .res_stall(res_stall),
    .res_valid(res_valid),
    .res      (res),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

endmodule

@@ rtl/core/fmv_sine.sv @@
// quarter-wave sine rom with phase to table index mapping
module fmv_sine #(
  parameter int SINE_TABLE_SIZE = fmv_pkg::DEF_SINE_TABLE_SIZE
) (
  input  logic        clk,
  input  logic        addr_en,
  input  logic        rd_en,
  input  logic [63:0] prod,
  output logic [14:0] mag,
  output logic        neg
);

  localparam int QUARTER_LEN = SINE_TABLE_SIZE / 4;
  localparam int IDX_W       = $clog2(SINE_TABLE_SIZE + 1);
  localparam int AW          = $clog2(QUARTER_LEN + 1);
  localparam longint unsigned QLEN        = 64'(QUARTER_LEN);
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned TAYLOR_DIV [7] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210
  };
  localparam logic [IDX_W-1:0] TABLE_N = IDX_W'(SINE_TABLE_SIZE);
  localparam logic [IDX_W-1:0] Q1 = IDX_W'(QUARTER_LEN);
  localparam logic [IDX_W-1:0] Q2 = IDX_W'(2 * QUARTER_LEN);
  localparam logic [IDX_W-1:0] Q3 = IDX_W'(3 * QUARTER_LEN);

  typedef logic [14:0] qrom_t [QUARTER_LEN + 1];

  function automatic logic [14:0] quarter_value(input int unsigned i);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned v;
    longint          sum;
    x   = (HALF_PI_Q30 * 64'(i) + QLEN / 2) / QLEN;
    x2  = (x * x) >> 30;
    t   = x;
    sum = 64'(x);
    for (int k = 0; k < 7; k++) begin
      t = ((t * x2) >> 30) / TAYLOR_DIV[k];
      if (!k[0]) begin
        sum = sum - 64'(t);
      end else begin
        sum = sum + 64'(t);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    v = (64'(sum) * 64'd32767 + 64'd536870912) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[14:0];
  endfunction

  function automatic qrom_t build_qrom();
    qrom_t r;
    for (int i = 0; i <= QUARTER_LEN; i++) begin
      r[i] = quarter_value(unsigned'(i));
    end
    return r;
  endfunction

  localparam qrom_t QROM = build_qrom();

  logic [63:0]      rounded;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] wrapped;
  logic [IDX_W-1:0] rem;
  logic [1:0]       quad;
  logic [AW-1:0]    addr;
  logic [AW-1:0]    addr_r;
  logic             neg_r;

  assign rounded = prod + 64'h0000_0000_8000_0000;
  assign idx     = rounded[32 +: IDX_W];
  assign wrapped = (idx == TABLE_N) ? '0 : idx;

  always_comb begin
    priority if (wrapped >= Q3) begin
      quad = 2'd3;
      rem  = wrapped - Q3;
    end else if (wrapped >= Q2) begin
      quad = 2'd2;
      rem  = wrapped - Q2;
    end else if (wrapped >= Q1) begin
      quad = 2'd1;
      rem  = wrapped - Q1;
    end else begin
      quad = 2'd0;
      rem  = wrapped;
    end
  end

  // odd quadrants read the table backwards
  assign addr = quad[0] ? AW'(Q1 - rem) : AW'(rem);

  always_ff @(posedge clk) begin
    if (addr_en) begin
      addr_r <= addr;
      neg_r  <= quad[1];
    end
    if (rd_en) begin
      mag <= QROM[addr_r];
      neg <= neg_r;
    end
  end

endmodule

@@ rtl/core/fmv_useq.sv @@
// microprogram sequencer: step counter, control store and branch logic
module fmv_useq (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  fmv_pkg::stat_t stat,
  output logic           busy,
  output fmv_pkg::ctrl_t ctrl
);

  logic [fmv_pkg::PC_W-1:0] pc;
  logic [fmv_pkg::PC_W-1:0] pc_next;
  fmv_pkg::ctrl_t           word;
  logic                     taken;
  logic                     hold;

  assign word = fmv_pkg::UCODE[pc];

  // an emit step waits while the previous result is still stalled
  assign hold = busy && stat.out_full &&
                (word.act == fmv_pkg::ACT_EMIT || word.act == fmv_pkg::ACT_EMIT_ZERO);

  always_comb begin
    case (word.cond)
      fmv_pkg::CD_NOT_TICK: taken = stat.kind != fmv_pkg::KIND_TICK;
      fmv_pkg::CD_SILENT:   taken = !stat.sounding;
      fmv_pkg::CD_STOP:     taken = stat.kind == fmv_pkg::KIND_STOP;
      fmv_pkg::CD_UNUSED:   taken = stat.kind == fmv_pkg::KIND_UNUSED;
      default:              taken = 1'b0;
    endcase
  end

  always_comb begin
    case (word.seq)
      fmv_pkg::SQ_BRANCH: pc_next = taken ? word.target : pc + fmv_pkg::PC_W'(1);
      fmv_pkg::SQ_END:    pc_next = fmv_pkg::ST_DISPATCH;
      default:            pc_next = pc + fmv_pkg::PC_W'(1);
    endcase
  end

  always_comb begin
    ctrl = word;
    if (!busy || hold) begin
      ctrl.mul = fmv_pkg::MA_NONE;
      ctrl.act = fmv_pkg::ACT_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= fmv_pkg::ST_DISPATCH;
    end else if (!busy) begin
      busy <= start;
      pc   <= fmv_pkg::ST_DISPATCH;
    end else if (!hold) begin
      pc <= pc_next;
      if (word.seq == fmv_pkg::SQ_END) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/core/fmv_dpath.sv @@
// voice datapath: shared multiplier, phase and step registers, result register
module fmv_dpath #(
  parameter int SAMPLE_RATE     = fmv_pkg::DEF_SAMPLE_RATE,
  parameter int SINE_TABLE_SIZE = fmv_pkg::DEF_SINE_TABLE_SIZE
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_take,
  input  fmv_pkg::cmd_t                 cmd,
  input  fmv_pkg::ctrl_t                ctrl,
  output fmv_pkg::stat_t                stat,
  input  logic                          res_stall,
  output logic                          res_valid,
  output fmv_pkg::res_t                 res,
  input  logic                          cfg_we,
  input  logic [fmv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                   cfg_data
);

  localparam longint unsigned NOTE_DEN = 64'(16 * SAMPLE_RATE);
  localparam longint unsigned SEMITONE_Q30 [12] = '{
    64'd1073741824, 64'd1137589836, 64'd1205234447, 64'd1276901417,
    64'd1352829926, 64'd1433273380, 64'd1518500250, 64'd1608794974,
    64'd1704458901, 64'd1805811301, 64'd1913190429, 64'd2026954652
  };
  localparam logic [31:0] TABLE_N       = 32'(SINE_TABLE_SIZE);
  localparam logic [31:0] CYCLE_PER_RAD = 32'd683565276;
  localparam logic [31:0] OUT_GAIN      = 32'd112288;

  typedef logic [31:0] note_rom_t [128];

  function automatic note_rom_t build_notes();
    note_rom_t       r;
    longint unsigned num;
    int              m;
    for (int n = 0; n < 128; n++) begin
      m    = n + 3;
      num  = (64'd440 * SEMITONE_Q30[m % 12]) << (m / 12);
      r[n] = 32'((num + NOTE_DEN / 2) / NOTE_DEN);
    end
    return r;
  endfunction

  localparam note_rom_t NOTE_ROM = build_notes();

  logic [15:0] mod_ratio;
  logic [15:0] mod_index;
  logic [31:0] cphase;
  logic [31:0] mphase;
  logic [31:0] cstep;
  logic [31:0] mstep;
  logic [6:0]  amp;
  logic        sounding;

  logic [1:0]  kind_r;
  logic [6:0]  note_r;
  logic [6:0]  vel_r;

  logic [63:0] prod;
  logic [31:0] arg;
  logic [31:0] mul_a;
  logic [31:0] mul_b;

  logic [14:0] sin_mag;
  logic        sin_neg;

  logic [63:0] off_round;
  logic [31:0] off;
  logic [63:0] out_round;
  logic [15:0] mag_out;
  logic [63:0] ms_round;
  logic        emit;

  fmv_sine #(
    .SINE_TABLE_SIZE(SINE_TABLE_SIZE)
  ) u_sine (
    .clk    (clk),
    .addr_en(ctrl.act == fmv_pkg::ACT_ADDR),
    .rd_en  (ctrl.act == fmv_pkg::ACT_ROM),
    .prod   (prod),
    .mag    (sin_mag),
    .neg    (sin_neg)
  );

  always_comb begin
    case (ctrl.mul)
      fmv_pkg::MA_MPHASE_N: begin
        mul_a = mphase;
        mul_b = TABLE_N;
      end
      fmv_pkg::MA_INDEX_ROM: begin
        mul_a = {16'd0, mod_index};
        mul_b = {17'd0, sin_mag};
      end
      fmv_pkg::MA_P_CPR: begin
        mul_a = prod[31:0];
        mul_b = CYCLE_PER_RAD;
      end
      fmv_pkg::MA_ARG_N: begin
        mul_a = arg;
        mul_b = TABLE_N;
      end
      fmv_pkg::MA_ROM_AMP: begin
        mul_a = {17'd0, sin_mag};
        mul_b = {25'd0, amp};
      end
      fmv_pkg::MA_P_GAIN: begin
        mul_a = prod[31:0];
        mul_b = OUT_GAIN;
      end
      fmv_pkg::MA_CSTEP_RATIO: begin
        mul_a = cstep;
        mul_b = {16'd0, mod_ratio};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // offset magnitude rounded half up, then signed by the modulator sine
  assign off_round = prod + 64'h0000_0000_4000_0000;
  assign off       = off_round[62:31];
  assign out_round = prod + 64'h0000_0000_0080_0000;
  assign mag_out   = out_round[39:24];
  assign ms_round  = prod + 64'd2048;
  assign emit      = ctrl.act == fmv_pkg::ACT_EMIT || ctrl.act == fmv_pkg::ACT_EMIT_ZERO;

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      kind_r <= cmd.kind;
      note_r <= cmd.note;
      vel_r  <= cmd.velocity;
    end
    if (ctrl.mul != fmv_pkg::MA_NONE) begin
      prod <= 64'(mul_a) * 64'(mul_b);
    end
    if (ctrl.act == fmv_pkg::ACT_ARG) begin
      arg <= cphase + (sin_neg ? 32'd0 - off : off);
    end
    if (ctrl.act == fmv_pkg::ACT_EMIT) begin
      res.sample       <= sin_neg ? 16'd0 - mag_out : mag_out;
      res.voice_active <= 1'b1;
    end else if (ctrl.act == fmv_pkg::ACT_EMIT_ZERO) begin
      res.sample       <= '0;
      res.voice_active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mod_ratio <= fmv_pkg::MOD_RATIO_RST;
      mod_index <= fmv_pkg::MOD_INDEX_RST;
      cphase    <= '0;
      mphase    <= '0;
      cstep     <= '0;
      mstep     <= '0;
      amp       <= '0;
      sounding  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          fmv_pkg::CFG_MOD_RATIO: mod_ratio <= cfg_data;
          fmv_pkg::CFG_MOD_INDEX: mod_index <= cfg_data;
        endcase
      end
      case (ctrl.act)
        fmv_pkg::ACT_EMIT: begin
          cphase <= cphase + cstep;
          mphase <= mphase + mstep;
        end
        fmv_pkg::ACT_LOAD: begin
          cstep  <= NOTE_ROM[note_r];
          amp    <= vel_r;
          cphase <= '0;
          mphase <= '0;
        end
        fmv_pkg::ACT_MSTEP: begin
          mstep    <= ms_round[43:12];
          sounding <= 1'b1;
        end
        fmv_pkg::ACT_STOP: sounding <= 1'b0;
        default: ;
      endcase
      if (emit) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  assign stat.kind     = kind_r;
  assign stat.sounding = sounding;
  assign stat.out_full = res_valid && res_stall;

endmodule

@@ rtl/core/fmv_checker.sv @@
// port-level checks for the fm voice oscillator, bound to the top level
module fmv_checker (
  input logic          clk,
  input logic          rst,
  input logic          cmd_valid,
  input logic          cmd_stall,
  input logic          res_valid,
  input logic          res_stall,
  input fmv_pkg::res_t res
);

  // a stalled result beat holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("result beat changed while stalled");

  // every command keeps the program busy for at least one step
  a_busy_after_cmd: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall |=> cmd_stall)
    else $error("command taken without busy step");

  // a silent voice only gives zero samples
  a_silent_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.voice_active |-> res.sample == 16'sd0)
    else $error("silent result with nonzero sample");

  // a new result only comes out of a running program
  a_res_from_prog: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(cmd_stall))
    else $error("result without a running command");

endmodule

bind fm_voice_oscillator_core fmv_checker u_fmv_checker (
  .clk      (clk),
  .rst      (rst),
  .cmd_valid(cmd_valid),
  .cmd_stall(cmd_stall),
  .res_valid(res_valid),
  .res_stall(res_stall),
  .res      (res)
);

@@ bench/tb_fm_voice_oscillator_core.sv @@
`timescale 1ns / 100ps
// self-checking bench for the fm voice oscillator core: directed plan, then random phases
module tb_fm_voice_oscillator_core;

  localparam int RATE        = fmv_pkg::DEF_SAMPLE_RATE;
  localparam int TABLE_LEN   = fmv_pkg::DEF_SINE_TABLE_SIZE;
  localparam int QUARTER     = TABLE_LEN / 4;
  localparam int N_PLAN      = 26;
  localparam int N_PHASES    = 10;
  localparam int PHASE_ITEMS = 90;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE      = 40;
  localparam int LIMIT       = 1000000;
  localparam int MAX_REPORTS = 100;

  typedef struct packed {
    fmv_pkg::cmd_t c;
    logic          pinned;
    fmv_pkg::res_t r;
  } plan_row_t;

  logic                          clk;
  logic                          rst;
  logic                          cmd_valid;
  logic                          cmd_stall;
  fmv_pkg::cmd_t                 cmd;
  logic                          res_valid;
  logic                          res_stall;
  fmv_pkg::res_t                 res;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [fmv_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [15:0]                   cfg_data;

  logic [15:0] ratio_q;
  logic [15:0] depth_q;
  logic [31:0] carrier_ph;
  logic [31:0] modulator_ph;
  logic [31:0] carrier_inc;
  logic [31:0] modulator_inc;
  logic [6:0]  level;
  logic        sounding;
  logic [15:0] quarter_tab [0:QUARTER];

  fmv_pkg::res_t samples_due [$];
  logic          row_pinned;
  fmv_pkg::res_t row_res;
  bit            got;
  fmv_pkg::res_t predicted;
  fmv_pkg::res_t due;
  int            errors = 0;
  int            cycles = 0;
  int            burst_left = 0;
  int            hold_asked = 0;
  int            hold_served = 0;

  fm_voice_oscillator_core dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  function automatic logic [15:0] quarter_point(input int unsigned i);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] v;
    longint      acc;
    int          k;
    x = (64'd1686629713 * 64'(i) + 64'(QUARTER / 2)) / 64'(QUARTER);
    x2 = (x * x) >> 30;
    t = x;
    acc = longint'(x);
    for (k = 1; k <= 7; k++) begin
      t = ((t * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) acc = acc - longint'(t);
      else acc = acc + longint'(t);
    end
    if (acc < 0) acc = 0;
    v = (64'(acc) * 64'd32767 + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) v = 64'd32767;
    return v[15:0];
  endfunction

  function automatic int sine_at(input logic [31:0] ph);
    logic [63:0] pos;
    int unsigned i;
    int unsigned quad;
    int unsigned r;
    int          v;
    pos = ((64'(ph) * 64'(TABLE_LEN)) + (64'd1 << 31)) >> 32;
    i = int'(pos % 64'(TABLE_LEN));
    quad = (i / QUARTER) % 4;
    r = i % QUARTER;
    if (quad == 0 || quad == 2) v = int'(quarter_tab[r]);
    else v = int'(quarter_tab[QUARTER - r]);
    return (quad >= 2) ? -v : v;
  endfunction

  function automatic logic [31:0] note_increment(input logic [6:0] n);
    int unsigned m;
    int unsigned oct;
    int unsigned k;
    logic [63:0] semi;
    logic [63:0] num;
    logic [63:0] den;
    m = n + 3;
    oct = m / 12;
    k = m % 12;
    case (k)
      0: semi = 64'd1073741824;
      1: semi = 64'd1137589836;
      2: semi = 64'd1205234447;
      3: semi = 64'd1276901417;
      4: semi = 64'd1352829926;
      5: semi = 64'd1433273380;
      6: semi = 64'd1518500250;
      7: semi = 64'd1608794974;
      8: semi = 64'd1704458901;
      9: semi = 64'd1805811301;
      10: semi = 64'd1913190429;
      default: semi = 64'd2026954652;
    endcase
    num = (64'd440 * semi) << oct;
    den = 64'(16 * RATE);
    return 32'((num + den / 2) / den);
  endfunction

  function automatic void voice_step(input fmv_pkg::cmd_t c, output bit has,
                                     output fmv_pkg::res_t r);
    int          s_mod;
    int          s_car;
    logic [63:0] mag;
    logic [63:0] prod;
    logic [63:0] amp;
    logic [31:0] offset;
    logic [15:0] v;
    has = 1'b0;
    r = '0;
    case (c.kind)
      fmv_pkg::KIND_NOTE: begin
        carrier_inc = note_increment(c.note);
        modulator_inc = 32'((64'(carrier_inc) * 64'(ratio_q) + 64'd2048) >> 12);
        level = c.velocity;
        carrier_ph = '0;
        modulator_ph = '0;
        sounding = 1'b1;
      end
      fmv_pkg::KIND_STOP: sounding = 1'b0;
      fmv_pkg::KIND_TICK: begin
        has = 1'b1;
        if (sounding) begin
          s_mod = sine_at(modulator_ph);
          mag = 64'((s_mod < 0) ? -s_mod : s_mod);
          prod = 64'(depth_q) * mag * 64'd683565276;
          offset = 32'((prod + (64'd1 << 30)) >> 31);
          if (s_mod < 0) offset = -offset;
          s_car = sine_at(carrier_ph + offset);
          mag = 64'((s_car < 0) ? -s_car : s_car);
          amp = (mag * 64'(level) * 64'd112288 + (64'd1 << 23)) >> 24;
          v = amp[15:0];
          r.sample = (s_car < 0) ? -v : v;
          r.voice_active = 1'b1;
          carrier_ph = carrier_ph + carrier_inc;
          modulator_ph = modulator_ph + modulator_inc;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic plan_row_t plan_row(input logic [1:0] k, input logic [6:0] n,
                                         input logic [6:0] vel, input logic pin,
                                         input logic signed [15:0] s, input logic act);
    plan_row_t p;
    p.c.kind = k;
    p.c.note = n;
    p.c.velocity = vel;
    p.pinned = pin;
    p.r.sample = s;
    p.r.voice_active = act;
    return p;
  endfunction

  task automatic send_cmd(input fmv_pkg::cmd_t c, input logic pin, input fmv_pkg::res_t r);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        cmd_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    cmd_valid <= 1'b1;
    cmd <= c;
    row_pinned <= pin;
    row_res <= r;
    do @(posedge clk); while (cmd_stall);
  endtask

  task automatic write_reg(input logic [fmv_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic close_phase();
    @(negedge clk);
    cmd_valid <= 1'b0;
    burst_left = 0;
    while (samples_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("%0t: timeout with %0d samples outstanding", $time, samples_due.size());
      $display("FAIL fm_voice_oscillator_core");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == fmv_pkg::CFG_MOD_RATIO) ratio_q = cfg_data;
        else if (cfg_index == fmv_pkg::CFG_MOD_INDEX) depth_q = cfg_data;
      end
      if (cmd_valid && !cmd_stall) begin
        voice_step(cmd, got, predicted);
        if (got) samples_due.push_back(row_pinned ? row_res : predicted);
      end
      if (res_valid && !res_stall) begin
        if (samples_due.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: expected no beat, got sample %0d active %0b", $time,
                     res.sample, res.voice_active);
        end else begin
          due = samples_due.pop_front();
          if (res.sample !== due.sample) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("%0t: sample expected %0d got %0d", $time, due.sample, res.sample);
          end
          if (res.voice_active !== due.voice_active) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("%0t: voice_active expected %0b got %0b", $time, due.voice_active,
                       res.voice_active);
          end
        end
      end
    end
  end

  // receiver: random stall modes plus one long hold-off on request
  initial begin : receiver
    int mode;
    int left;
    int pct;
    left = 0;
    pct = 0;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      if (hold_asked != hold_served) begin
        hold_served = hold_asked;
        res_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        res_stall <= 1'b0;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(2);
          left = $urandom_range(1, 60);
          pct = (mode == 0) ? 0 : (mode == 1) ? 25 : 75;
        end
        left--;
        res_stall <= ($urandom_range(99) < pct);
      end
    end
  end

  initial begin : stimulus
    plan_row_t     plan [N_PLAN];
    fmv_pkg::cmd_t c;
    int            i;
    int            ph;
    int            sent;
    int            pick;
    logic [15:0]   ratio_pick;
    logic [15:0]   depth_pick;
    rst = 1'b1;
    cmd_valid = 1'b0;
    cmd = '0;
    res_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    row_pinned = 1'b0;
    row_res = '0;
    for (i = 0; i <= QUARTER; i++) quarter_tab[i] = quarter_point(i);
    ratio_q = fmv_pkg::MOD_RATIO_RST;
    depth_q = fmv_pkg::MOD_INDEX_RST;
    carrier_ph = '0;
    modulator_ph = '0;
    carrier_inc = '0;
    modulator_inc = '0;
    level = '0;
    sounding = 1'b0;

    // first tick of any note sees both phases at zero, so its sample is zero
    plan = '{
      plan_row(fmv_pkg::KIND_TICK,   7'd0,   7'd0,   1'b1, 16'sd0, 1'b0),
      plan_row(fmv_pkg::KIND_UNUSED, 7'd127, 7'd127, 1'b0, 16'sd0, 1'b0),
      plan_row(fmv_pkg::KIND_TICK,   7'd127, 7'd127, 1'b1, 16'sd0, 1'b0),
      plan_row(fmv_pkg::KIND_NOTE,   7'd69,  7'd127, 1'b0, 16'sd0, 1'b0),
      plan_row(fmv_pkg::KIND_TICK,   7'd0,   7'd0,   1'b1, 16'sd0, 1'b1),
      plan_row(fmv_pkg::KIND_TICK,   7'd0,   7'd0,   1'b0, 16'sd0, 1'b0),
      plan_row(fmv_pkg::KIND_TICK,   7'd0,   7'd0,   1'b0, 16'sd0, 1'b0),
      plan_row(fmv_pkg::KIND_STOP,   7'd0,   7'd0,   1'b0, 16'sd0, 1'b0),
      plan_row(fmv_pkg::KIND_TICK,   7'd0,   7'd0,   1'b1, 16'sd0, 1'b0),
      plan_row(fmv_pkg::KIND_NOTE,   7'd0,   7'd127, 1'b0, 16'sd0, 1'b0),
      plan_row(fmv_pkg::KIND_TICK,   7'd0,   7'd0,   1'b1, 16'sd0, 1'b1),
      plan_row(fmv_pkg::KIND_TICK,   7'd0,   7'd0,   1'b0, 16'sd0, 1'b0),
      plan_row(fmv_pkg::KIND_NOTE,   7'd127, 7'd127, 1'b0, 16'sd0, 1'b0),
      plan_row(fmv_pkg::KIND_TICK,   7'd0,   7'd0,   1'b1, 16'sd0, 1'b1),
      plan_row(fmv_pkg::KIND_TICK,   7'd0,   7'd0,   1'b0, 16'sd0, 1'b0),
      plan_row(fmv_pkg::KIND_NOTE,   7'd60,  7'd0,   1'b0, 16'sd0, 1'b0),
      plan_row(fmv_pkg::KIND_TICK,   7'd0,   7'd0,   1'b1, 16'sd0, 1'b1),
      plan_row(fmv_pkg::KIND_TICK,   7'd0,   7'd0,   1'b1, 16'sd0, 1'b1),
      plan_row(fmv_pkg::KIND_UNUSED, 7'd0,   7'd0,   1'b0, 16'sd0, 1'b0),
      plan_row(fmv_pkg::KIND_TICK,   7'd0,   7'd0,   1'b1, 16'sd0, 1'b1),
      plan_row(fmv_pkg::KIND_NOTE,   7'd127, 7'd1,   1'b0, 16'sd0, 1'b0),
      plan_row(fmv_pkg::KIND_TICK,   7'd0,   7'd0,   1'b1, 16'sd0, 1'b1),
      plan_row(fmv_pkg::KIND_TICK,   7'd0,   7'd0,   1'b0, 16'sd0, 1'b0),
      plan_row(fmv_pkg::KIND_STOP,   7'd0,   7'd0,   1'b0, 16'sd0, 1'b0),
      plan_row(fmv_pkg::KIND_STOP,   7'd0,   7'd0,   1'b0, 16'sd0, 1'b0),
      plan_row(fmv_pkg::KIND_TICK,   7'd0,   7'd0,   1'b1, 16'sd0, 1'b0)
    };

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (i = 0; i < N_PLAN; i++) send_cmd(plan[i].c, plan[i].pinned, plan[i].r);
    close_phase();

    for (ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: begin
          ratio_pick = 16'h0000;
          depth_pick = 16'h0000;
        end
        1: begin
          ratio_pick = 16'hFFFF;
          depth_pick = 16'hFFFF;
        end
        2: begin
          ratio_pick = 16'h0000;
          depth_pick = 16'hFFFF;
        end
        3: begin
          ratio_pick = 16'hFFFF;
          depth_pick = 16'h0000;
        end
        default: begin
          ratio_pick = 16'($urandom_range(16'hFFFF));
          depth_pick = 16'($urandom_range(16'hFFFF));
        end
      endcase
      write_reg(fmv_pkg::CFG_MOD_RATIO, ratio_pick);
      write_reg(fmv_pkg::CFG_MOD_INDEX, depth_pick);
      if (ph == 4) hold_asked++;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        pick = $urandom_range(99);
        c.note = 7'($urandom_range(127));
        c.velocity = 7'($urandom_range(127));
        if (pick < 8) c.kind = fmv_pkg::KIND_NOTE;
        else if (pick < 11) c.kind = fmv_pkg::KIND_STOP;
        else if (pick < 14) c.kind = fmv_pkg::KIND_UNUSED;
        else c.kind = fmv_pkg::KIND_TICK;
        send_cmd(c, 1'b0, '0);
        if (c.kind != fmv_pkg::KIND_UNUSED) sent++;
      end
      close_phase();
    end

    if (errors == 0 && samples_due.size() == 0) begin
      $display("PASS fm_voice_oscillator_core");
    end else begin
      if (samples_due.size() != 0)
        $display("%0t: %0d samples never arrived", $time, samples_due.size());
      $display("FAIL fm_voice_oscillator_core");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/fmv_pkg.sv
rtl/core/fmv_sine.sv
rtl/core/fmv_useq.sv
rtl/core/fmv_dpath.sv
rtl/core/fm_voice_oscillator_core.sv
rtl/core/fmv_checker.sv
bench/tb_fm_voice_oscillator_core.sv
